FILE: rtl/ins_frame_sync_checksum_decoder_assert.svh
// Assertion macros shared by the frame decoder modules.
// The macros expect a signal named clk in the including module; IFSC_ASSERT also expects rst.
`ifndef INS_FRAME_SYNC_CHECKSUM_DECODER_ASSERT_SVH
`define INS_FRAME_SYNC_CHECKSUM_DECODER_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define IFSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IFSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ifsc_pkg.sv
// Shared types, constants and the frame field layout of the frame decoder.
// No dependencies; imported by ifsc_if, ifsc_ctrl, ifsc_dp, the top level and the testbench.
`default_nettype none

package ifsc_pkg;

  localparam int FRAME_BYTES = 170;
  localparam int ADDR_W      = 8;
  localparam int FIELD_COUNT = 41;
  localparam int FIELD_W     = 6;
  localparam int VALUE_W     = 64;
  localparam int FIELD_BASE  = 30;
  localparam int CHECK_POS   = 168;

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;

  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(FIELD_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_H0,
    ST_RD_H1,
    ST_RD_C0,
    ST_CHECK,
    ST_DECIDE,
    ST_FETCH,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RSEL_H0,
    RSEL_H1,
    RSEL_C0,
    RSEL_FIELD
  } rd_sel_t;

  typedef struct packed {
    logic [7:0] off;
    logic [3:0] size;
    logic       sgn;
  } field_desc_t;

  typedef struct packed {
    logic               rx_ready;
    rd_sel_t            rd_sel;
    logic               cap_h0;
    logic               cap_h1;
    logic               cap_c0;
    logic               slide;
    logic               flush;
    logic               asm_clr;
    logic               asm_en;
    logic [2:0]         asm_lane;
    logic               out_load;
    logic [FIELD_W-1:0] field;
    logic [2:0]         byte_k;
  } ifsc_cmd_t;

  typedef struct packed {
    logic rx_accept;
    logic fill_almost;
    logic frame_good;
    logic out_free;
  } ifsc_stat_t;

  function automatic field_desc_t fd(input logic [7:0] off, input logic [3:0] size,
                                     input logic sgn);
    field_desc_t d;
    d.off  = off;
    d.size = size;
    d.sgn  = sgn;
    return d;
  endfunction

  // Offset from the payload base, size in bytes and signedness of each field.
  function automatic field_desc_t field_desc(input logic [FIELD_W-1:0] idx);
    field_desc_t d;
    case (idx)
      6'd0:    d = fd(8'd0,   4'd2, 1'b0);
      6'd1:    d = fd(8'd2,   4'd2, 1'b1);
      6'd2:    d = fd(8'd4,   4'd2, 1'b1);
      6'd3:    d = fd(8'd6,   4'd4, 1'b1);
      6'd4:    d = fd(8'd10,  4'd4, 1'b1);
      6'd5:    d = fd(8'd14,  4'd4, 1'b1);
      6'd6:    d = fd(8'd18,  4'd4, 1'b1);
      6'd7:    d = fd(8'd22,  4'd4, 1'b1);
      6'd8:    d = fd(8'd26,  4'd4, 1'b1);
      6'd9:    d = fd(8'd30,  4'd2, 1'b1);
      6'd10:   d = fd(8'd32,  4'd2, 1'b1);
      6'd11:   d = fd(8'd34,  4'd2, 1'b1);
      6'd12:   d = fd(8'd36,  4'd2, 1'b0);
      6'd13:   d = fd(8'd38,  4'd2, 1'b0);
      6'd14:   d = fd(8'd40,  4'd2, 1'b1);
      6'd15:   d = fd(8'd42,  4'd8, 1'b1);
      6'd16:   d = fd(8'd50,  4'd8, 1'b1);
      6'd17:   d = fd(8'd58,  4'd4, 1'b1);
      6'd18:   d = fd(8'd62,  4'd4, 1'b1);
      6'd19:   d = fd(8'd66,  4'd4, 1'b1);
      6'd20:   d = fd(8'd70,  4'd4, 1'b1);
      6'd21:   d = fd(8'd74,  4'd8, 1'b1);
      6'd22:   d = fd(8'd82,  4'd8, 1'b1);
      6'd23:   d = fd(8'd90,  4'd4, 1'b1);
      6'd24:   d = fd(8'd94,  4'd4, 1'b1);
      6'd25:   d = fd(8'd98,  4'd2, 1'b0);
      6'd26:   d = fd(8'd100, 4'd4, 1'b1);
      6'd27:   d = fd(8'd104, 4'd4, 1'b0);
      6'd28:   d = fd(8'd108, 4'd1, 1'b0);
      6'd29:   d = fd(8'd109, 4'd1, 1'b0);
      6'd30:   d = fd(8'd110, 4'd1, 1'b0);
      6'd31:   d = fd(8'd111, 4'd2, 1'b0);
      6'd32:   d = fd(8'd113, 4'd1, 1'b0);
      6'd33:   d = fd(8'd114, 4'd2, 1'b0);
      6'd34:   d = fd(8'd116, 4'd2, 1'b1);
      6'd35:   d = fd(8'd118, 4'd1, 1'b0);
      6'd36:   d = fd(8'd119, 4'd1, 1'b0);
      6'd37:   d = fd(8'd120, 4'd2, 1'b0);
      6'd38:   d = fd(8'd122, 4'd2, 1'b0);
      6'd39:   d = fd(8'd124, 4'd4, 1'b1);
      6'd40:   d = fd(8'd128, 4'd1, 1'b0);
      default: d = fd(8'd0,   4'd1, 1'b0);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ifsc_if.sv
// Valid/ready channel interfaces for received bytes and decoded field words.
// Depends on ifsc_pkg for the field widths.
`default_nettype none

interface ifsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifsc_field_if;
  import ifsc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [FIELD_W-1:0]        field_index;
  logic signed [VALUE_W-1:0] field_value;
  logic                      last_field;

  modport source (output valid, output field_index, output field_value,
                  output last_field, input ready);
  modport sink (input valid, input field_index, input field_value,
                input last_field, output ready);
endinterface

`default_nettype wire

FILE: rtl/ins_frame_sync_checksum_decoder.sv
// Inertial unit frame synchronizer and checksum decoder, top level.
// Depends on ifsc_pkg, ifsc_if, ifsc_ram, ifsc_ctrl and ifsc_dp.
//
// Usage:
// The rx channel takes one received byte per word. Bytes are kept in a
// 170-byte sliding window held in a small RAM. While the window is not yet
// full rx stays ready and a byte is taken whenever one is offered.
// The byte that fills the window starts a frame test: three RAM reads fetch
// the header and low check byte, then the header and the 16-bit sum of
// bytes 2..167 are compared. A failed test drops the oldest byte, so every
// further byte starts a new test until a frame is found.
// A good frame sends 41 words on tx, field 0 first and last_field set on
// field 40. Each field is read one byte a cycle from the RAM port, and rx
// is held low during readout. A stall on tx holds the output register and
// the readout waits; the final word may still be pending while new bytes
// are taken. Reset empties the window and drops any pending word.
`default_nettype none

module ins_frame_sync_checksum_decoder (
  input  logic         clk,
  input  logic         rst,
  ifsc_byte_if.sink    rx,
  ifsc_field_if.source tx
);
  import ifsc_pkg::*;

  ifsc_cmd_t  cmd;
  ifsc_stat_t stat;

  ifsc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ifsc_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .rx   (rx),
    .tx   (tx)
  );

endmodule

`default_nettype wire

FILE: rtl/ifsc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ifsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 170,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/ifsc_ctrl.sv
// Sequencer of the frame decoder: frame test steps and field-by-field readout.
// Depends on ifsc_pkg and the assertion macro header.
`default_nettype none

module ifsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  ifsc_pkg::ifsc_stat_t  stat,
  output ifsc_pkg::ifsc_cmd_t   cmd
);
  import ifsc_pkg::*;
  `include "ins_frame_sync_checksum_decoder_assert.svh"

  ctrl_state_t        state, state_next;
  logic [FIELD_W-1:0] field, field_next;
  logic [3:0]         byte_k, byte_k_next;
  field_desc_t        fdesc;
  logic [3:0]         fsize;

  assign fdesc = field_desc(field);
  assign fsize = fdesc.size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      field  <= '0;
      byte_k <= '0;
    end else begin
      state  <= state_next;
      field  <= field_next;
      byte_k <= byte_k_next;
    end
  end

  always_comb begin
    state_next  = state;
    field_next  = field;
    byte_k_next = byte_k;
    case (state)
      ST_IDLE: begin
        if (stat.rx_accept && stat.fill_almost) begin
          state_next = ST_RD_H0;
        end
      end
      ST_RD_H0:  state_next = ST_RD_H1;
      ST_RD_H1:  state_next = ST_RD_C0;
      ST_RD_C0:  state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.frame_good) begin
          state_next  = ST_FETCH;
          field_next  = '0;
          byte_k_next = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        // The last byte of the field lands in the assembly register on this edge.
        if (byte_k == fsize) begin
          state_next = ST_EMIT;
        end else begin
          byte_k_next = byte_k + 4'd1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (field == LAST_FIELD) begin
            state_next = ST_IDLE;
          end else begin
            state_next  = ST_FETCH;
            field_next  = field + FIELD_W'(1);
            byte_k_next = '0;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RSEL_FIELD;
    cmd.field    = field;
    cmd.byte_k   = byte_k[2:0];
    cmd.asm_lane = 3'(byte_k - 4'd1);
    case (state)
      ST_IDLE:   cmd.rx_ready = 1'b1;
      ST_RD_H0:  cmd.rd_sel = RSEL_H0;
      ST_RD_H1: begin
        cmd.rd_sel = RSEL_H1;
        cmd.cap_h0 = 1'b1;
      end
      ST_RD_C0: begin
        cmd.rd_sel = RSEL_C0;
        cmd.cap_h1 = 1'b1;
      end
      ST_CHECK:  cmd.cap_c0 = 1'b1;
      ST_DECIDE: cmd.slide = !stat.frame_good;
      ST_FETCH: begin
        cmd.asm_clr = (byte_k == 4'd0);
        cmd.asm_en  = (byte_k != 4'd0);
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.flush    = stat.out_free && (field == LAST_FIELD);
      end
      default: cmd.rx_ready = 1'b0;
    endcase
  end

  `IFSC_ASSERT(a_fetch_bound, (state == ST_FETCH) |-> (byte_k <= fsize), "byte count past size")
  `IFSC_ASSERT(a_ready_idle, cmd.rx_ready |-> (state == ST_IDLE), "rx ready outside idle")
  `IFSC_ASSERT(a_flush_last, cmd.flush |-> (field == LAST_FIELD), "flush before last field")

endmodule

`default_nettype wire

FILE: rtl/ifsc_dp.sv
// Datapath of the frame decoder: byte window store, running sum, frame test,
// field assembly and the output register. Depends on ifsc_pkg, ifsc_if, ifsc_ram.
`default_nettype none

module ifsc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ifsc_pkg::ifsc_cmd_t  cmd,
  output ifsc_pkg::ifsc_stat_t stat,
  ifsc_byte_if.sink            rx,
  ifsc_field_if.source         tx
);
  import ifsc_pkg::*;
  `include "ins_frame_sync_checksum_decoder_assert.svh"

  logic [7:0]         fill;
  logic [ADDR_W-1:0]  start;
  logic [15:0]        sum;
  logic [7:0]         last_byte;
  logic [7:0]         h0, h1, c0;
  logic [VALUE_W-1:0] asm_word;

  logic                      out_valid;
  logic [FIELD_W-1:0]        out_idx;
  logic signed [VALUE_W-1:0] out_val;
  logic                      out_last;

  logic              accept;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        rdata;
  logic [7:0]        rpos;
  field_desc_t       desc;
  logic [15:0]       payload_sum;

  function automatic logic [ADDR_W-1:0] wrap_pos(input logic [ADDR_W-1:0] base,
                                                 input logic [7:0] pos);
    logic [8:0] s;
    s = {1'b0, base} + {1'b0, pos};
    if (s >= 9'(FRAME_BYTES)) begin
      s = s - 9'(FRAME_BYTES);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] extend(input logic [VALUE_W-1:0] v,
                                                input field_desc_t d);
    logic [VALUE_W-1:0] r;
    case (d.size)
      4'd1:    r = {{56{d.sgn & v[7]}}, v[7:0]};
      4'd2:    r = {{48{d.sgn & v[15]}}, v[15:0]};
      4'd4:    r = {{32{d.sgn & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  assign accept   = rx.valid && cmd.rx_ready;
  assign rx.ready = cmd.rx_ready;
  assign desc     = field_desc(cmd.field);
  assign waddr    = wrap_pos(start, fill);

  always_comb begin
    case (cmd.rd_sel)
      RSEL_H0:    rpos = 8'd0;
      RSEL_H1:    rpos = 8'd1;
      RSEL_C0:    rpos = 8'(CHECK_POS);
      RSEL_FIELD: rpos = 8'(FIELD_BASE) + desc.off + {5'b0, cmd.byte_k};
      default:    rpos = 8'd0;
    endcase
  end

  assign raddr = wrap_pos(start, rpos);

  ifsc_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (rx.rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The running sum covers all held bytes; remove the header and check bytes.
  assign payload_sum = sum - {8'd0, h0} - {8'd0, h1} - {8'd0, c0} - {8'd0, last_byte};

  assign stat.rx_accept   = accept;
  assign stat.fill_almost = (fill == 8'(FRAME_BYTES - 1));
  assign stat.frame_good  = (h0 == HDR0) && (h1 == HDR1) && (payload_sum == {last_byte, c0});
  assign stat.out_free    = !out_valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      start <= '0;
      sum   <= '0;
    end else if (accept) begin
      fill <= fill + 8'd1;
      sum  <= sum + {8'd0, rx.rx_byte};
    end else if (cmd.slide) begin
      fill  <= fill - 8'd1;
      sum   <= sum - {8'd0, h0};
      start <= (start == ADDR_W'(FRAME_BYTES - 1)) ? '0 : start + ADDR_W'(1);
    end else if (cmd.flush) begin
      fill <= '0;
      sum  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_byte <= rx.rx_byte;
    end
    if (cmd.cap_h0) begin
      h0 <= rdata;
    end
    if (cmd.cap_h1) begin
      h1 <= rdata;
    end
    if (cmd.cap_c0) begin
      c0 <= rdata;
    end
    if (cmd.asm_clr) begin
      asm_word <= '0;
    end else if (cmd.asm_en) begin
      asm_word[{cmd.asm_lane, 3'b000} +: 8] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx  <= cmd.field;
      out_val  <= extend(asm_word, desc);
      out_last <= (cmd.field == LAST_FIELD);
    end
  end

  assign tx.valid       = out_valid;
  assign tx.field_index = out_idx;
  assign tx.field_value = out_val;
  assign tx.last_field  = out_last;

  `IFSC_ASSERT(a_fill_range, fill <= 8'(FRAME_BYTES), "window fill beyond frame length")
  `IFSC_ASSERT(a_load_free, cmd.out_load |-> (!out_valid || tx.ready), "output word overwritten")
  `IFSC_ASSERT(a_slide_fill, cmd.slide |=> (fill == 8'(FRAME_BYTES - 1)), "slide left wrong fill")

endmodule

`default_nettype wire

FILE: tb/sv/tb_ins_frame_sync_checksum_decoder.sv
// Self-checking testbench for the inertial unit frame decoder: streams good, broken
// and noisy byte frames and checks every decoded field word against its own model.
// Depends on ifsc_pkg, ifsc_if and the ins_frame_sync_checksum_decoder RTL.
`default_nettype none

module tb_ins_frame_sync_checksum_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ifsc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 250;

  // Field sizes in bytes and signedness, in frame order. Fields are packed back to back
  // from the payload base, so offsets follow from the sizes.
  localparam logic [8*FIELD_COUNT-1:0] FIELD_SIZES =
    "22244444422222288444488442441112122112241";
  localparam logic [8*FIELD_COUNT-1:0] FIELD_SIGNS =
    "USSSSSSSSSSSUUSSSSSSSSSSSUSUUUUUUUSUUUUSU";

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_EDGE, FILL_RANDOM} frame_fill_t;

  typedef struct {
    logic [FIELD_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    logic               last;
  } field_word_t;

  logic clk;
  logic rst;

  ifsc_byte_if  rx();
  ifsc_field_if tx();

  ins_frame_sync_checksum_decoder dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .tx(tx)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model state: the sliding byte window.
  logic [7:0]  win_mem [FRAME_BYTES];
  int unsigned win_head;
  int unsigned win_count;

  field_word_t expected_fields[$];
  logic [7:0]  byte_q[$];
  logic [7:0]  frame_buf [FRAME_BYTES];

  int  snd_idle_pct;
  int  rcv_idle_pct;
  int  hold_req;
  int  hold_ack;
  int  hold_left;
  logic in_taken;
  int  quiet_cycles;
  int  errors;
  int  bytes_taken;
  int  words_checked;
  int  frames_found;

  function automatic logic [7:0] win_byte(input int unsigned pos);
    return win_mem[(win_head + pos) % FRAME_BYTES];
  endfunction

  // Stores one byte; once the window is full, tests the frame at its oldest byte and
  // either queues all decoded fields or slides the window by one.
  task automatic sync_byte(input logic [7:0] b);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [63:0] v;
    int unsigned off;
    int unsigned size;
    field_word_t w;
    int i;
    int k;
    win_mem[(win_head + win_count) % FRAME_BYTES] = b;
    win_count++;
    if (win_count < FRAME_BYTES) return;
    sum = '0;
    for (i = 2; i < CHECK_POS; i++) sum += 16'(win_byte(i));
    chk = {win_byte(CHECK_POS + 1), win_byte(CHECK_POS)};
    if (win_byte(0) == HDR0 && win_byte(1) == HDR1 && sum == chk) begin
      off = FIELD_BASE;
      for (i = 0; i < FIELD_COUNT; i++) begin
        size = FIELD_SIZES[8*(FIELD_COUNT-1-i) +: 8] - 8'h30;
        v = '0;
        for (k = 0; k < size; k++) v |= 64'(win_byte(off + k)) << (8 * k);
        if (FIELD_SIGNS[8*(FIELD_COUNT-1-i) +: 8] == "S" && size < 8 && v[8*size-1])
          v |= ~64'd0 << (8 * size);
        w.idx   = FIELD_W'(i);
        w.value = v;
        w.last  = (i == FIELD_COUNT - 1);
        expected_fields.push_back(w);
        off += size;
      end
      win_count = 0;
      frames_found++;
    end else begin
      win_head = (win_head + 1) % FRAME_BYTES;
      win_count--;
    end
  endtask

  task automatic check_field();
    field_word_t e;
    if (expected_fields.size() == 0) begin
      $error("unexpected field word: index %0d value %h", tx.field_index, tx.field_value);
      errors++;
      return;
    end
    e = expected_fields.pop_front();
    words_checked++;
    if (tx.field_index !== e.idx) begin
      $error("field_index: expected %0d, got %0d", e.idx, tx.field_index);
      errors++;
    end
    if (tx.field_value !== e.value) begin
      $error("field_value (field %0d): expected %h, got %h", e.idx, e.value, tx.field_value);
      errors++;
    end
    if (tx.last_field !== e.last) begin
      $error("last_field (field %0d): expected %0b, got %0b", e.idx, e.last, tx.last_field);
      errors++;
    end
  endtask

  // Monitor and model update; outputs are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= rx.valid && rx.ready;
      if (tx.valid && tx.ready) check_field();
      if (rx.valid && rx.ready) begin
        sync_byte(rx.rx_byte);
        bytes_taken++;
      end
      if ((rx.valid && rx.ready) || (tx.valid && tx.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Byte driver: a word stays on the bus until it has been taken.
  always @(negedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
    end else if (!rx.valid || in_taken) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        rx.valid   <= 1'b1;
        rx.rx_byte <= byte_q.pop_front();
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  // Field receiver, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      tx.ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      tx.ready  <= 1'b0;
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      tx.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  // Fills frame_buf with a well-formed frame: header, payload and its checksum.
  function automatic void build_frame(input frame_fill_t fill);
    logic [15:0] sum;
    int i;
    sum = '0;
    frame_buf[0] = HDR0;
    frame_buf[1] = HDR1;
    for (i = 2; i < CHECK_POS; i++) begin
      case (fill)
        FILL_ZERO: frame_buf[i] = 8'h00;
        FILL_ONES: frame_buf[i] = 8'hFF;
        FILL_EDGE: frame_buf[i] = edge_byte();
        default:   frame_buf[i] = ($urandom_range(3) == 0) ? edge_byte() : 8'($urandom);
      endcase
      sum += 16'(frame_buf[i]);
    end
    frame_buf[CHECK_POS]     = sum[7:0];
    frame_buf[CHECK_POS + 1] = sum[15:8];
  endfunction

  function automatic void push_frame(input int len);
    int i;
    for (i = 0; i < len; i++) byte_q.push_back(frame_buf[i]);
  endfunction

  function automatic void push_noise(input int len);
    int i;
    int r;
    for (i = 0; i < len; i++) begin
      r = $urandom_range(9);
      byte_q.push_back(r < 2 ? HDR0 : (r < 4 ? HDR1 : 8'($urandom)));
    end
  endfunction

  // The sender stops until every queued byte is taken and every field has arrived.
  task automatic drain();
    while (byte_q.size() != 0 || rx.valid || expected_fields.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    rx.valid     = 1'b0;
    rx.rx_byte   = 8'h00;
    tx.ready     = 1'b0;
    snd_idle_pct = 33;
    rcv_idle_pct = 58;
    hold_req     = 0;
    hold_ack     = 0;
    hold_left    = 0;
    errors       = 0;
    bytes_taken  = 0;
    words_checked = 0;
    frames_found = 0;
    win_head     = 0;
    win_count    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // A frame of sign boundary values behind a short noise run. One of the windows
    // tested on the way starts with a right header but carries a wrong checksum.
    byte_q.push_back(HDR0);
    byte_q.push_back(HDR0);
    byte_q.push_back(HDR1);
    byte_q.push_back(8'h00);
    build_frame(FILL_EDGE);
    push_frame(FRAME_BYTES);
    drain();

    // A cut frame slides out ahead of an all-ones frame, and noise is left behind.
    snd_idle_pct = 58;
    rcv_idle_pct = 33;
    build_frame(FILL_RANDOM);
    push_frame($urandom_range(24, 8));
    build_frame(FILL_ONES);
    push_frame(FRAME_BYTES);
    push_noise($urandom_range(12, 4));
    drain();

    // No idling; the receiver holds off long enough for the block to stall its input.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    build_frame(FILL_RANDOM);
    push_frame(FRAME_BYTES);
    push_noise(12);
    hold_req++;
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes under three idle profiles and one long output stall;",
             bytes_taken);
    $display("decoded %0d frames and checked %0d field words.", frames_found, words_checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timed out after %0d cycles without a transfer.", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/ifsc_pkg.sv
rtl/ifsc_if.sv
rtl/ifsc_ram.sv
rtl/ifsc_ctrl.sv
rtl/ifsc_dp.sv
rtl/ins_frame_sync_checksum_decoder.sv
tb/sv/tb_ins_frame_sync_checksum_decoder.sv
